FILE: src/ta2d_pkg.sv
// package for the table atan2 unit: arctangent table, widths and angle constants
`default_nettype none
package ta2d_pkg;

  localparam int IN_W       = 16;
  localparam int MAG_W      = 17;
  localparam int ANGLE_W    = 8;
  localparam int OCT_W      = 6;
  localparam int QUAD_W     = 7;
  localparam int ATAN_STEPS = 64;
  localparam int ATAN_ENTRIES = ATAN_STEPS + 1;

  localparam logic [QUAD_W-1:0]  RIGHT_ANGLE    = QUAD_W'(90);
  localparam logic [ANGLE_W-1:0] STRAIGHT_ANGLE = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] ANGLE_MAX      = ANGLE_W'(127);

  // first-octant arctangent in degrees, indexed by 64 * small / big
  localparam logic [OCT_W-1:0] ATAN_DEG [0:ATAN_ENTRIES-1] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,
    6'd9,  6'd10, 6'd11, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd21, 6'd22, 6'd23, 6'd24, 6'd24,
    6'd25, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd31,
    6'd32, 6'd33, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd36, 6'd37, 6'd37,
    6'd38, 6'd39, 6'd39, 6'd40, 6'd40, 6'd41, 6'd41, 6'd42, 6'd42, 6'd43,
    6'd43, 6'd44, 6'd44, 6'd45, 6'd45
  };

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic swap;
    logic zero;
  } ang_flags_t;

endpackage
`default_nettype wire

FILE: src/table_atan2_degrees_unit.sv
// table atan2 unit: four-quadrant arctangent in whole degrees, fully pipelined
//
// usage: drive in_x_component and in_y_component and raise start for one
// cycle per item; a beat is taken at each rising edge with start high and
// busy low. busy is always low, so a new item may enter every cycle.
// results come out on out_angle_degrees with out_valid high for exactly one
// cycle, in the order the items went in; the receiver cannot hold them off.
// the pipeline is one magnitude stage, QW restoring divider stages (one per
// quotient bit, QW = clog2(TABLE_STEPS + 1), 7 at the default of 64), a
// table stage and a quadrant stage. throughput: one item per cycle.
// reset: rst_n is synchronous, active low; it clears all valid bits, so
// items in flight are dropped and no result appears until new items enter.
// there is no configuration and no state between items.
`default_nettype none
module table_atan2_degrees_unit
  import ta2d_pkg::*;
#(
  parameter int TABLE_STEPS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [IN_W-1:0]    in_x_component,
  input  wire logic signed [IN_W-1:0]    in_y_component,
  output logic                           out_valid,
  output logic signed [ANGLE_W-1:0]      out_angle_degrees
);

  localparam int QW = $clog2(TABLE_STEPS + 1);
  localparam int NW = MAG_W + QW;

  // quotient to first-octant angle, built at elaboration
  logic [OCT_W-1:0] oct_map [0:TABLE_STEPS];

  for (genvar q = 0; q <= TABLE_STEPS; q++) begin : g_map
    localparam int IDX = (q * ATAN_STEPS) / TABLE_STEPS;
    assign oct_map[q] = ATAN_DEG[IDX];
  end

  assign busy = 1'b0;

  // magnitude and octant swap
  logic [MAG_W-1:0] mag_x, mag_y, small_mag, big_mag;
  logic [NW-1:0]    num_full;
  ang_flags_t       flags_in;

  always_comb begin
    flags_in.neg_x = in_x_component[IN_W-1];
    flags_in.neg_y = in_y_component[IN_W-1];
    mag_x = flags_in.neg_x ? (MAG_W'(1) << IN_W) - MAG_W'(unsigned'(in_x_component))
                           : MAG_W'(unsigned'(in_x_component));
    mag_y = flags_in.neg_y ? (MAG_W'(1) << IN_W) - MAG_W'(unsigned'(in_y_component))
                           : MAG_W'(unsigned'(in_y_component));
    flags_in.swap = mag_x < mag_y;
    flags_in.zero = (mag_x == '0) && (mag_y == '0);
    small_mag = flags_in.swap ? mag_x : mag_y;
    big_mag   = flags_in.swap ? mag_y : mag_x;
    num_full  = NW'(small_mag) * NW'(TABLE_STEPS);
  end

  // divider pipeline, entry s holds the item before quotient bit QW-1-s
  logic             vld_r   [0:QW];
  ang_flags_t       flg_r   [0:QW];
  logic [MAG_W-1:0] big_r   [0:QW];
  logic [MAG_W-1:0] rem_r   [0:QW];
  logic [QW-1:0]    lo_r    [0:QW];
  logic [QW-1:0]    quo_r   [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
    end
    flg_r[0] <= flags_in;
    big_r[0] <= big_mag;
    rem_r[0] <= num_full[NW-1:QW];
    lo_r[0]  <= num_full[QW-1:0];
    quo_r[0] <= '0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [MAG_W:0]   shifted;
    logic             take;
    logic [MAG_W-1:0] rem_nxt;
    logic [QW-1:0]    quo_nxt;

    always_comb begin
      shifted = {rem_r[s], lo_r[s][QW-1-s]};
      take    = shifted >= {1'b0, big_r[s]};
      rem_nxt = take ? MAG_W'(shifted - {1'b0, big_r[s]}) : MAG_W'(shifted);
      quo_nxt = {quo_r[s][QW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      flg_r[s+1] <= flg_r[s];
      big_r[s+1] <= big_r[s];
      rem_r[s+1] <= rem_nxt;
      lo_r[s+1]  <= lo_r[s];
      quo_r[s+1] <= quo_nxt;
    end
  end

  // table stage
  logic              tab_vld_r;
  ang_flags_t        tab_flg_r;
  logic [QUAD_W-1:0] tab_ang_r, tab_ang_nxt;
  logic [OCT_W-1:0]  oct_ang;

  always_comb begin
    oct_ang     = oct_map[quo_r[QW]];
    tab_ang_nxt = flg_r[QW].swap ? RIGHT_ANGLE - QUAD_W'(oct_ang) : QUAD_W'(oct_ang);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_vld_r <= 1'b0;
    end else begin
      tab_vld_r <= vld_r[QW];
    end
    tab_flg_r <= flg_r[QW];
    tab_ang_r <= tab_ang_nxt;
  end

  // quadrant stage: left half-plane reflect with saturation, then sign; a zero input gives 0
  logic                     out_valid_r;
  logic [ANGLE_W-1:0]       out_ang_r, out_ang_nxt;
  logic [ANGLE_W-1:0]       refl, half;

  always_comb begin
    refl = STRAIGHT_ANGLE - ANGLE_W'(tab_ang_r);
    if (tab_flg_r.neg_x) begin
      half = (refl > ANGLE_MAX) ? ANGLE_MAX : refl;
    end else begin
      half = ANGLE_W'(tab_ang_r);
    end
    if (tab_flg_r.zero) begin
      out_ang_nxt = '0;
    end else if (tab_flg_r.neg_y) begin
      out_ang_nxt = ANGLE_W'(0) - half;
    end else begin
      out_ang_nxt = half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tab_vld_r;
    end
    out_ang_r <= out_ang_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_angle_degrees = signed'(out_ang_r);

endmodule
`default_nettype wire
